>>> hw/rtl/rate_limited_pursuit_heading_defines.svh
// Assertion helpers shared by the RTL.
`ifndef RATE_LIMITED_PURSUIT_HEADING_DEFINES_SVH
`define RATE_LIMITED_PURSUIT_HEADING_DEFINES_SVH

// Same-cycle implication.
`define RLPH_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlph: implication check failed");

// Next-cycle implication.
`define RLPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlph: next-cycle check failed");

`endif

>>> hw/rtl/rlph_pkg.sv
package rlph_pkg;

   localparam int TGT_W      = 12;
   localparam int DT_W       = 16;
   localparam int POS_W      = 18;
   localparam int HEAD_W     = 16;
   localparam int RATE_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int PROD_W     = 32;
   localparam int Z_W        = 32;
   localparam int ATAN_IDX_W = 5;

   localparam logic [Z_W-1:0]    QUARTER_TURN = 32'h4000_0000;
   localparam logic [RATE_W-1:0] MOVE_RATE_RST = 16'd84;
   localparam logic [RATE_W-1:0] TURN_RATE_RST = 16'd1074;
   localparam logic signed [POS_W-1:0] CUR_X_RST = 18'sd25600;
   localparam logic signed [POS_W-1:0] CUR_Y_RST = 18'sd19200;
   localparam logic signed [POS_W-1:0] POS_MAX   = 18'sh1FFFF;
   localparam logic signed [POS_W-1:0] POS_MIN   = 18'sh20000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MOVE_RATE,
      REG_TURN_RATE
   } csr_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_MOVE,
      ST_MUL_TURN,
      ST_WAIT,
      ST_STEP,
      ST_COMMIT
   } state_type;

   // atan(2^-i), 2^32 units per turn
   function automatic logic [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic [Z_W-1:0] v;
      case (idx)
         5'd0:  v = 32'h2000_0000;
         5'd1:  v = 32'h12E4_051E;
         5'd2:  v = 32'h09FB_385B;
         5'd3:  v = 32'h0511_11D4;
         5'd4:  v = 32'h028B_0D43;
         5'd5:  v = 32'h0145_D7E1;
         5'd6:  v = 32'h00A2_F61E;
         5'd7:  v = 32'h0051_7C55;
         5'd8:  v = 32'h0028_BE53;
         5'd9:  v = 32'h0014_5F2F;
         5'd10: v = 32'h000A_2F98;
         5'd11: v = 32'h0005_17CC;
         5'd12: v = 32'h0002_8BE6;
         5'd13: v = 32'h0001_45F3;
         5'd14: v = 32'h0000_A2FA;
         5'd15: v = 32'h0000_517D;
         5'd16: v = 32'h0000_28BE;
         5'd17: v = 32'h0000_145F;
         5'd18: v = 32'h0000_0A30;
         5'd19: v = 32'h0000_0518;
         5'd20: v = 32'h0000_028C;
         5'd21: v = 32'h0000_0146;
         5'd22: v = 32'h0000_00A3;
         5'd23: v = 32'h0000_0051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> hw/rtl/rlph_cordic.sv
// Vectoring CORDIC, one micro-rotation per cycle through a shared add/shift datapath.
module rlph_cordic #(
   parameter int DW           = 19,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic signed [DW-1:0]  dx,
   input  logic signed [DW-1:0]  dy,
   output logic                  done,
   output logic [ANGLE_BITS-1:0] bearing
);
   import rlph_pkg::*;

   localparam int CW    = DW + 2;
   localparam int CNT_W = $clog2(CORDIC_STEPS);
   // rounding to ANGLE_BITS folded into the starting angle (z is modular)
   localparam logic [Z_W-1:0] ROUND_C = Z_W'(1) << (31 - ANGLE_BITS);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic              zero_ff, zero_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic signed [CW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [Z_W-1:0]    z_ff, z_in;
   logic signed [CW-1:0] xs, ys, dxw, dyw;
   logic [Z_W-1:0]    atan_c;
   logic              last;

   assign dxw    = CW'(dx);
   assign dyw    = CW'(dy);
   assign xs     = cx_ff >>> cnt_ff;
   assign ys     = cy_ff >>> cnt_ff;
   assign atan_c = atan_entry(ATAN_IDX_W'(cnt_ff));
   assign last   = (cnt_ff == CNT_W'(CORDIC_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      cx_in   = cx_ff;
      cy_in   = cy_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         zero_in = (dx == '0) && (dy == '0);
         if (dx < 0) begin
            if (dy >= 0) begin
               cx_in = dyw;
               cy_in = -dxw;
               z_in  = QUARTER_TURN + ROUND_C;
            end else begin
               cx_in = -dyw;
               cy_in = dxw;
               z_in  = ROUND_C - QUARTER_TURN;
            end
         end else begin
            cx_in = dxw;
            cy_in = dyw;
            z_in  = ROUND_C;
         end
      end else if (busy_ff) begin
         if (cy_ff > 0) begin
            cx_in = cx_ff + ys;
            cy_in = cy_ff - xs;
            z_in  = z_ff + atan_c;
         end else begin
            cx_in = cx_ff - ys;
            cy_in = cy_ff + xs;
            z_in  = z_ff - atan_c;
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      zero_ff <= zero_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      z_ff    <= z_in;
   end

   assign done    = done_ff;
   assign bearing = zero_ff ? '0 : z_ff[Z_W-1 -: ANGLE_BITS];

endmodule

>>> hw/rtl/rate_limited_pursuit_heading.sv
// Channel   Direction  Handshake                 Payload
// req_      in         req_valid / req_ready     target_x, target_y, elapsed_us
// rsp_      out        rsp_valid / rsp_ready     pos_x, pos_y, heading
// csr_      in         csr_we (no wait)          csr_index, csr_wdata
//
// An accepted item runs through the shared multiplier, then the CORDIC loop (one
// micro-rotation per cycle), then the step and commit states.
// Both rate limits share one 16x16 multiplier, move limit first, then turn limit.
// reset is synchronous; after it, the block takes an item at once.
// A stalled result holds the block in its commit step; a new item may be taken
// while the previous result still waits.
`include "rate_limited_pursuit_heading_defines.svh"

module rate_limited_pursuit_heading #(
   parameter int FRAC_BITS    = 6,
   parameter int ANGLE_BITS   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [rlph_pkg::TGT_W-1:0]     req_target_x,
   input  logic signed [rlph_pkg::TGT_W-1:0]     req_target_y,
   input  logic [rlph_pkg::DT_W-1:0]             req_elapsed_us,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rlph_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [rlph_pkg::POS_W-1:0]     rsp_pos_y,
   output logic [rlph_pkg::HEAD_W-1:0]           rsp_heading,
   input  logic                                  csr_we,
   input  logic [rlph_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rlph_pkg::RATE_W-1:0]           csr_wdata
);
   import rlph_pkg::*;

   localparam int TW    = TGT_W + FRAC_BITS;
   localparam int DW    = ((TW > POS_W) ? TW : POS_W) + 1;
   localparam int SUM_W = DW + 1;
   localparam int HW    = ((ANGLE_BITS > RATE_W) ? ANGLE_BITS : RATE_W) + 2;

   state_type state_ff, state_in;

   logic [RATE_W-1:0] move_rate_ff, turn_rate_ff;
   logic rsp_valid_ff, rsp_valid_in;

   logic signed [DW-1:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [DT_W-1:0]      dt_ff, dt_in;
   logic [RATE_W-1:0]    mstep_ff, mstep_in, tstep_ff, tstep_in;
   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DW-1:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic signed [HW-1:0] turn_ff, turn_in;
   logic signed [POS_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [ANGLE_BITS-1:0]   cur_heading_ff, cur_heading_in;

   logic [RATE_W-1:0]   mul_a;
   logic [PROD_W-1:0]   prod;
   logic                cordic_start, cordic_done;
   logic [ANGLE_BITS-1:0] bearing;

   logic signed [DW-1:0]  mv_lim, step_x_c, step_y_c;
   logic signed [ANGLE_BITS-1:0] diff;
   logic signed [HW-1:0]  tn_lim, diff_w, turn_c, head_sum;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic signed [POS_W-1:0] sat_x, sat_y;

   // shared multiplier: move limit first, then turn limit
   assign mul_a = (state_ff == ST_MUL_TURN) ? turn_rate_ff : move_rate_ff;
   assign prod  = PROD_W'(mul_a) * PROD_W'(dt_ff);

   rlph_cordic #(
      .DW           (DW),
      .ANGLE_BITS   (ANGLE_BITS),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cordic_start),
      .dx      (dx_ff),
      .dy      (dy_ff),
      .done    (cordic_done),
      .bearing (bearing)
   );

   // limits and clamps
   assign mv_lim   = DW'($signed({1'b0, mstep_ff}));
   assign step_x_c = (dx_ff > mv_lim) ? mv_lim : ((dx_ff < -mv_lim) ? -mv_lim : dx_ff);
   assign step_y_c = (dy_ff > mv_lim) ? mv_lim : ((dy_ff < -mv_lim) ? -mv_lim : dy_ff);

   // half a turn lands on the negative side
   assign diff   = $signed(bearing - cur_heading_ff);
   assign diff_w = HW'(diff);
   assign tn_lim = HW'($signed({1'b0, tstep_ff}));
   assign turn_c = (diff_w > tn_lim) ? tn_lim : ((diff_w < -tn_lim) ? -tn_lim : diff_w);

   assign sum_x = SUM_W'(cur_x_ff) + SUM_W'(step_x_ff);
   assign sum_y = SUM_W'(cur_y_ff) + SUM_W'(step_y_ff);
   assign sat_x = (sum_x > SUM_W'(POS_MAX)) ? POS_MAX :
                  ((sum_x < SUM_W'(POS_MIN)) ? POS_MIN : sum_x[POS_W-1:0]);
   assign sat_y = (sum_y > SUM_W'(POS_MAX)) ? POS_MAX :
                  ((sum_y < SUM_W'(POS_MIN)) ? POS_MIN : sum_y[POS_W-1:0]);
   assign head_sum = HW'($signed({1'b0, cur_heading_ff})) + turn_ff;

   always_comb begin
      state_in       = state_ff;
      req_ready      = 1'b0;
      cordic_start   = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      tgt_x_in       = tgt_x_ff;
      tgt_y_in       = tgt_y_ff;
      dt_in          = dt_ff;
      mstep_in       = mstep_ff;
      tstep_in       = tstep_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      step_x_in      = step_x_ff;
      step_y_in      = step_y_ff;
      turn_in        = turn_ff;
      cur_x_in       = cur_x_ff;
      cur_y_in       = cur_y_ff;
      cur_heading_in = cur_heading_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               tgt_x_in = DW'(req_target_x) <<< FRAC_BITS;
               tgt_y_in = DW'(req_target_y) <<< FRAC_BITS;
               dt_in    = req_elapsed_us;
               state_in = ST_MUL_MOVE;
            end
         end
         ST_MUL_MOVE: begin
            mstep_in = prod[PROD_W-1 -: RATE_W];
            dx_in    = tgt_x_ff - DW'(cur_x_ff);
            dy_in    = tgt_y_ff - DW'(cur_y_ff);
            state_in = ST_MUL_TURN;
         end
         ST_MUL_TURN: begin
            tstep_in     = prod[PROD_W-1 -: RATE_W];
            cordic_start = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (cordic_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            step_x_in = step_x_c;
            step_y_in = step_y_c;
            turn_in   = turn_c;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // position registers double as the result; wait for the slot
            if (!rsp_valid_ff || rsp_ready) begin
               cur_x_in       = sat_x;
               cur_y_in       = sat_y;
               cur_heading_in = head_sum[ANGLE_BITS-1:0];
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         move_rate_ff   <= MOVE_RATE_RST;
         turn_rate_ff   <= TURN_RATE_RST;
         cur_x_ff       <= CUR_X_RST;
         cur_y_ff       <= CUR_Y_RST;
         cur_heading_ff <= '0;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
         cur_x_ff       <= cur_x_in;
         cur_y_ff       <= cur_y_in;
         cur_heading_ff <= cur_heading_in;
         if (csr_we) begin
            unique case (csr_reg_type'(csr_index))
               REG_MOVE_RATE: move_rate_ff <= csr_wdata;
               REG_TURN_RATE: turn_rate_ff <= csr_wdata;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      tgt_x_ff  <= tgt_x_in;
      tgt_y_ff  <= tgt_y_in;
      dt_ff     <= dt_in;
      mstep_ff  <= mstep_in;
      tstep_ff  <= tstep_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      step_x_ff <= step_x_in;
      step_y_ff <= step_y_in;
      turn_ff   <= turn_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = cur_x_ff;
   assign rsp_pos_y   = cur_y_ff;
   assign rsp_heading = HEAD_W'(cur_heading_ff);

   `RLPH_ASSERT_IMPL(a_done_in_wait, clock, reset, cordic_done, state_ff == ST_WAIT)
   `RLPH_ASSERT_IMPL(a_step_bounded, clock, reset, state_ff == ST_COMMIT, (step_x_ff <= mv_lim) && (step_x_ff >= -mv_lim) && (step_y_ff <= mv_lim) && (step_y_ff >= -mv_lim))
   `RLPH_ASSERT_NEXT(a_commit_holds, clock, reset, (state_ff == ST_COMMIT) && rsp_valid_ff && !rsp_ready, (state_ff == ST_COMMIT) && $stable(cur_x_ff) && $stable(cur_heading_ff))

endmodule
